// ----- hdl/smbc_pkg.sv -----
// Shared constants and types for the bank conflict counter.
// No dependencies; compiled first.
package smbc_pkg;

	localparam int ADDR_W  = 32;
	localparam int DEPTH_W = 7;
	localparam int CONF_W  = 6;
	localparam int ACC_W   = 7;

	// one result word
	typedef struct packed {
		logic [DEPTH_W-1:0] max_depth;
		logic [CONF_W-1:0]  total_conflicts;
		logic [ACC_W-1:0]   access_count;
	} res_t;

endpackage

// ----- hdl/smbc_if.sv -----
// Valid/ready channel interfaces for access words and result words.
// Depends on smbc_pkg for the field widths.
interface smbc_access_if;
	logic                        valid;
	logic                        ready;
	logic [smbc_pkg::ADDR_W-1:0] address;
	logic                        last;

	modport source (output valid, output address, output last, input ready);
	modport sink   (input valid, input address, input last, output ready);
endinterface

interface smbc_result_if;
	logic                         valid;
	logic                         ready;
	logic [smbc_pkg::DEPTH_W-1:0] max_depth;
	logic [smbc_pkg::CONF_W-1:0]  total_conflicts;
	logic [smbc_pkg::ACC_W-1:0]   access_count;

	modport source (output valid, output max_depth, output total_conflicts,
		output access_count, input ready);
	modport sink   (input valid, input max_depth, input total_conflicts,
		input access_count, output ready);
endinterface

// ----- hdl/smbc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/smbc_queue.sv -----
// Small FIFO between the classify front end and the counting back end.
// No dependencies.
module smbc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/smbc_front.sv -----
// Front end: accepts access words and maps each address to its bank.
// Depends on smbc_pkg and smbc_if.
module smbc_front #(
	parameter int NUM_BANKS  = 32,
	parameter int BANK_BYTES = 4,
	localparam int BW = $clog2(NUM_BANKS)
) (
	input  logic           clk,
	input  logic           arst_n,
	smbc_access_if.sink    access,
	output logic           push_valid,
	output logic [BW-1:0]  push_bank,
	output logic           push_last,
	input  logic           push_ready
);
	import smbc_pkg::*;

	// bank = (addr mod M) / BANK_BYTES, with M = BANK_BYTES * NUM_BANKS
	localparam int M    = BANK_BYTES * NUM_BANKS;
	localparam int MW   = $clog2(M);
	localparam int C1   = 256 % M;
	localparam int C2   = 65536 % M;
	localparam int C3   = (1 << 24) % M;
	localparam int XMAX = 255 * (1 + C1 + C2 + C3);
	localparam int XW   = $clog2(XMAX + 1);
	localparam int PW   = 2 * XW;
	localparam int R    = (1 << XW) / M;
	localparam int RB   = ((1 << 20) + BANK_BYTES - 1) / BANK_BYTES;

	logic          en;
	logic          v_s1, v_s2, v_s3, v_s4;
	logic          last_s1, last_s2, last_s3, last_s4;
	logic [XW-1:0] x_s1, x_s2;
	logic [XW-1:0] q_s2;
	logic [MW-1:0] rm_s3;
	logic [BW-1:0] bank_s4;

	logic [31:0]   fold;
	logic [PW-1:0] prod_q;
	logic [31:0]   rem, rem_fix;
	logic [31:0]   prod_b;

	assign en           = !v_s4 || push_ready;
	assign access.ready = en;

	// byte fold: addr mod M is congruent to sum of bytes times 256^i mod M
	assign fold = 32'(access.address[7:0])
		+ 32'(access.address[15:8]) * 32'(C1)
		+ 32'(access.address[23:16]) * 32'(C2)
		+ 32'(access.address[31:24]) * 32'(C3);

	// quotient estimate, low by at most one
	assign prod_q  = PW'(x_s1) * PW'(R);
	assign rem     = 32'(x_s2) - 32'(q_s2) * 32'(M);
	assign rem_fix = (rem >= 32'(M)) ? rem - 32'(M) : rem;
	// exact for rm < 1024 and BANK_BYTES <= 16
	assign prod_b  = 32'(rm_s3) * 32'(RB);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= XW'(fold);
			last_s1 <= access.last;
			x_s2    <= x_s1;
			q_s2    <= prod_q[PW-1:XW];
			last_s2 <= last_s1;
			rm_s3   <= MW'(rem_fix);
			last_s3 <= last_s2;
			bank_s4 <= BW'(prod_b >> 20);
			last_s4 <= last_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= access.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign push_valid = v_s4;
	assign push_bank  = bank_s4;
	assign push_last  = last_s4;

endmodule

// ----- hdl/smbc_back.sv -----
// Back end: per-bank read-modify-write, group totals and result register.
// Depends on smbc_pkg, smbc_if and smbc_ram.
module smbc_back #(
	parameter int NUM_BANKS = 32,
	parameter int MAX_GROUP = 64,
	localparam int BW = $clog2(NUM_BANKS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  logic [BW-1:0] q_bank,
	input  logic          q_last,
	output logic          q_pop,
	smbc_result_if.source result
);
	import smbc_pkg::*;

	localparam int CW = $clog2(MAX_GROUP + 1);
	localparam int KW = $clog2(MAX_GROUP);

	logic                 v_s1, last_s1;
	logic [BW-1:0]        bank_s1;
	logic [NUM_BANKS-1:0] vld_q;
	logic                 fwd_q;
	logic [CW-1:0]        fwd_cnt_q;
	logic [CW-1:0]        depth_q, acc_q;
	logic [KW-1:0]        conf_q;
	res_t                 res_q;
	logic                 res_v_q;

	logic          stall, adv, we;
	logic [BW-1:0] raddr;
	logic [CW-1:0] rd_data, cnt_old, cnt_new, depth_new, acc_new;
	logic [KW-1:0] conf_new;

	assign stall = v_s1 && last_s1 && res_v_q && !result.ready;
	assign adv   = v_s1 && !stall;
	assign q_pop = q_valid && (!v_s1 || adv);
	assign raddr = q_pop ? q_bank : bank_s1;
	assign we    = adv && !last_s1;

	smbc_ram #(.WIDTH(CW), .DEPTH(NUM_BANKS)) u_cnt_ram (
		.clk  (clk),
		.we   (we),
		.waddr(bank_s1),
		.wdata(cnt_new),
		.raddr(raddr),
		.rdata(rd_data)
	);

	// untouched banks read as zero; a write at the read edge is forwarded
	assign cnt_old   = !vld_q[bank_s1] ? '0 : (fwd_q ? fwd_cnt_q : rd_data);
	assign cnt_new   = (cnt_old < CW'(MAX_GROUP)) ? cnt_old + 1'b1 : cnt_old;
	assign conf_new  = (cnt_old != '0 && conf_q < KW'(MAX_GROUP - 1)) ?
		conf_q + 1'b1 : conf_q;
	assign depth_new = (cnt_new > depth_q) ? cnt_new : depth_q;
	assign acc_new   = (acc_q < CW'(MAX_GROUP)) ? acc_q + 1'b1 : acc_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			bank_s1 <= q_bank;
			last_s1 <= q_last;
		end
		fwd_cnt_q <= cnt_new;
		if (adv && last_s1) begin
			res_q.max_depth       <= DEPTH_W'(depth_new);
			res_q.total_conflicts <= CONF_W'(conf_new);
			res_q.access_count    <= ACC_W'(acc_new);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			vld_q   <= '0;
			fwd_q   <= 1'b0;
			depth_q <= '0;
			acc_q   <= '0;
			conf_q  <= '0;
			res_v_q <= 1'b0;
		end else begin
			if (q_pop) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			fwd_q <= we && (raddr == bank_s1);
			if (adv) begin
				if (last_s1) begin
					vld_q   <= '0;
					depth_q <= '0;
					acc_q   <= '0;
					conf_q  <= '0;
				end else begin
					vld_q[bank_s1] <= 1'b1;
					depth_q        <= depth_new;
					acc_q          <= acc_new;
					conf_q         <= conf_new;
				end
			end
			if (adv && last_s1) begin
				res_v_q <= 1'b1;
			end else if (result.ready) begin
				res_v_q <= 1'b0;
			end
		end
	end

	assign result.valid           = res_v_q;
	assign result.max_depth       = res_q.max_depth;
	assign result.total_conflicts = res_q.total_conflicts;
	assign result.access_count    = res_q.access_count;

endmodule

// ----- hdl/shared_memory_bank_conflict_counter.sv -----
// Top level of the shared memory bank conflict counter.
// Depends on smbc_pkg, smbc_if, smbc_front, smbc_queue, smbc_back, smbc_ram.
//
//  channel  dir  handshake      payload
//  access   in   valid/ready    address[31:0], last
//  result   out  valid/ready    max_depth[6:0], total_conflicts[5:0], access_count[6:0]
//
// Throughput is one access word per cycle unless a stalled result holds the
// counting stage. The accepting edge loads the first of four bank-mapping stages;
// the word then passes the queue and the counting stage into the result register,
// which turns valid as a group's last word leaves the counting stage. The rate is set
// by the single per-bank read-modify-write there, which forwards a same-bank write.
// Reset is asynchronous (arst_n low) and clears the group counters and all valid bits.
// A stalled result only holds back the next group's last word; the queue
// absorbs the rest before access.ready drops.
module shared_memory_bank_conflict_counter #(
	parameter int NUM_BANKS  = 32,
	parameter int BANK_BYTES = 4,
	parameter int MAX_GROUP  = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	smbc_access_if.sink   access,
	smbc_result_if.source result
);
	import smbc_pkg::*;

	localparam int BW      = $clog2(NUM_BANKS);
	localparam int Q_DEPTH = 4;

	// front -> queue
	logic          push_valid, push_last, q_full;
	logic [BW-1:0] push_bank;
	// queue -> back, entry is {bank, last}
	logic [BW:0]   q_dout;
	logic          q_empty, q_pop;

	smbc_front #(.NUM_BANKS(NUM_BANKS), .BANK_BYTES(BANK_BYTES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.access    (access),
		.push_valid(push_valid),
		.push_bank (push_bank),
		.push_last (push_last),
		.push_ready(!q_full)
	);

	smbc_queue #(.WIDTH(BW + 1), .DEPTH(Q_DEPTH)) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push_valid && !q_full),
		.din   ({push_bank, push_last}),
		.full  (q_full),
		.pop   (q_pop),
		.dout  (q_dout),
		.empty (q_empty)
	);

	smbc_back #(.NUM_BANKS(NUM_BANKS), .MAX_GROUP(MAX_GROUP)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(!q_empty),
		.q_bank (q_dout[BW:1]),
		.q_last (q_dout[0]),
		.q_pop  (q_pop),
		.result (result)
	);

endmodule

// ----- hdl/smbc_checker.sv -----
// Port-level checks on result words of the bank conflict counter.
// Depends on smbc_pkg; bound to shared_memory_bank_conflict_counter.
module smbc_checker #(
	parameter int MAX_GROUP = 64
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic [smbc_pkg::DEPTH_W-1:0] max_depth,
	input logic [smbc_pkg::CONF_W-1:0]  total_conflicts,
	input logic [smbc_pkg::ACC_W-1:0]   access_count
);
	import smbc_pkg::*;

	// fields cannot wrap while the saturation limit fits the conflict field
	localparam bit NO_WRAP = (MAX_GROUP <= 64);

	// a group holds at least one access and its deepest bank fits inside it
	a_depth_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && NO_WRAP |-> max_depth != '0
			&& 8'(max_depth) <= 8'(access_count))
		else $error("max_depth outside 1..access_count");

	// every access beyond the first in the deepest bank is a conflict
	a_depth_vs_conf: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && NO_WRAP |-> 8'(max_depth) <= 8'(total_conflicts) + 8'd1)
		else $error("max_depth exceeds total_conflicts + 1");

	a_conf_vs_acc: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && NO_WRAP |-> 8'(total_conflicts) < 8'(access_count))
		else $error("total_conflicts not below access_count");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(max_depth)
			&& $stable(total_conflicts) && $stable(access_count))
		else $error("stalled result word changed");

endmodule

bind shared_memory_bank_conflict_counter smbc_checker #(.MAX_GROUP(MAX_GROUP)) u_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.max_depth      (result.max_depth),
	.total_conflicts(result.total_conflicts),
	.access_count   (result.access_count)
);
